[src/ilha_pkg.sv]
// Package for the implicit list heap allocator: sizes, codes, address and
// init helpers. No dependencies.
package ilha_pkg;

  localparam int unsigned HEAP_BYTES  = 65536;
  localparam int unsigned CHUNK_BYTES = 4096;
  localparam int unsigned HEAP_WORDS  = HEAP_BYTES / 4;
  localparam int unsigned AW          = $clog2(HEAP_WORDS);
  localparam int unsigned BW          = $clog2(HEAP_BYTES + 1);

  localparam logic [31:0] SIZE_MASK = 32'hFFFF_FFF8;
  localparam logic [31:0] MIN_BLOCK = 32'd16;

  // first chunk, rounded to an even word count
  localparam int unsigned CHUNK_SZ  = (CHUNK_BYTES / 4 + (CHUNK_BYTES / 4) % 2) * 4;
  localparam bit          INIT_FITS = (16 + CHUNK_SZ) <= HEAP_BYTES;
  localparam int unsigned BRK_INIT  = INIT_FITS ? 16 + CHUNK_SZ : 16;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_ZERO = 2'd1;
  localparam logic [1:0] ST_OOM  = 2'd2;

  // byte offset to word index, wrapping over the heap
  function automatic logic [AW-1:0] waddr(input logic [31:0] b);
    waddr = b[AW+1:2];
  endfunction

  // heap contents after reset, one word at a time
  function automatic logic [31:0] init_word(input logic [AW-1:0] a);
    logic [31:0] w;
    w = '0;
    if (a == AW'(1) || a == AW'(2)) begin
      w = 32'd9;
    end else if (INIT_FITS) begin
      if (a == AW'(3) || a == AW'((16 + CHUNK_SZ - 8) / 4)) begin
        w = 32'(CHUNK_SZ);
      end else if (a == AW'((16 + CHUNK_SZ - 4) / 4)) begin
        w = 32'd1;
      end
    end else if (a == AW'(3)) begin
      w = 32'd1;
    end
    init_word = w;
  endfunction

endpackage

[src/ilha_if.sv]
// Handshake channels of the allocator: request in, result out.
// Depends on nothing.
interface ilha_in_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [15:0] req_size;
  logic [15:0] block_addr;
  modport source (output valid, opcode, req_size, block_addr, input ready);
  modport sink   (input valid, opcode, req_size, block_addr, output ready);
endinterface

interface ilha_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] payload_addr;
  logic [1:0]  status;
  modport source (output valid, payload_addr, status, input ready);
  modport sink   (input valid, payload_addr, status, output ready);
endinterface

[src/ilha_ram.sv]
// Single-port-write, registered-read word RAM holding the heap.
// Depends on nothing.
module ilha_ram #(
  parameter int unsigned AW = 14,
  parameter int unsigned DW = 32
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] wa_i,
  input  logic [DW-1:0] wd_i,
  input  logic          re_i,
  input  logic [AW-1:0] ra_i,
  output logic [DW-1:0] rd_o
);
  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[wa_i] <= wd_i;
    end
    if (re_i) begin
      rd_o <= mem[ra_i];
    end
  end
endmodule

[src/implicit_list_heap_allocator.sv]
// Top level of the implicit list heap allocator (first fit, boundary tags).
// Depends on ilha_pkg, ilha_in_if / ilha_out_if and ilha_ram.
//
// channel | dir | fields                              | transfer when
// in_i    | in  | opcode, req_size, block_addr        | valid & ready
// out_o   | out | payload_addr, status                | valid & ready
//
// One item at a time. The heap lives in a 16384 x 32 RAM with registered reads;
// each step makes at most one RAM access. Free clears the tag pair, then merges;
// allocate walks block headers first fit, grows and merges the heap when no
// block fits, then places, so the walk over heap occupancy sets the rate.
// After reset an init pass writes every heap word; no request is taken
// until it ends. A result waiting on out_o does not block the next request;
// the block stalls only before writing its next result.
module implicit_list_heap_allocator (
  input  logic    clk_i,
  input  logic    rst_ni,
  ilha_in_if.sink    in_i,
  ilha_out_if.source out_o
);
  import ilha_pkg::*;

  localparam logic [4:0] S_INIT  = 5'd0;
  localparam logic [4:0] S_IDLE  = 5'd1;
  localparam logic [4:0] S_F_RD  = 5'd2;   // free: read header
  localparam logic [4:0] S_F_W   = 5'd3;
  localparam logic [4:0] S_S_ISS = 5'd4;   // scan: issue header read
  localparam logic [4:0] S_S_CHK = 5'd5;
  localparam logic [4:0] S_GROW  = 5'd6;
  localparam logic [4:0] S_G_EPI = 5'd7;
  localparam logic [4:0] S_M_H   = 5'd8;   // merge: read own header
  localparam logic [4:0] S_M_P   = 5'd9;   // merge: read previous footer
  localparam logic [4:0] S_M_N   = 5'd10;  // merge: read next header
  localparam logic [4:0] S_M_E   = 5'd11;
  localparam logic [4:0] S_P_RD  = 5'd12;  // place: read header
  localparam logic [4:0] S_P_W   = 5'd13;
  localparam logic [4:0] S_P_SPL = 5'd14;
  localparam logic [4:0] S_T_H   = 5'd15;  // tag pair: header write
  localparam logic [4:0] S_T_F   = 5'd16;  // tag pair: footer write
  localparam logic [4:0] S_DONE  = 5'd17;
  localparam logic [4:0] S_RES   = 5'd18;

  logic [4:0]    state_q, tret_q, mret_q;
  logic [AW-1:0] cnt_q;
  logic [BW-1:0] brk_q;
  logic [32:0]   bp_q;
  logic [31:0]   asize_q, tbp_q, tsz_q, msz_q, pf_q, csz_q;
  logic          tal_q, op_q;
  logic [15:0]   res_addr_q, out_addr_q;
  logic [1:0]    res_st_q, out_st_q;
  logic          out_vld_q;

  logic          we, re;
  logic [AW-1:0] wa, ra;
  logic [31:0]   wd, rdata;

  logic [31:0] bp32;
  logic [31:0] ext, gsize;
  assign bp32  = bp_q[31:0];
  assign ext   = (asize_q > 32'(CHUNK_BYTES)) ? asize_q : 32'(CHUNK_BYTES);
  assign gsize = ((ext & 32'hFFFF_FFFC) + 32'd4) & SIZE_MASK;

  ilha_ram #(.AW(AW), .DW(32)) u_ram (
    .clk_i (clk_i),
    .we_i  (we),
    .wa_i  (wa),
    .wd_i  (wd),
    .re_i  (re),
    .ra_i  (ra),
    .rd_o  (rdata)
  );

  // RAM port per state
  always_comb begin
    we = 1'b0;
    wa = '0;
    wd = '0;
    re = 1'b0;
    ra = '0;
    case (state_q)
      S_INIT: begin
        we = 1'b1;
        wa = cnt_q;
        wd = init_word(cnt_q);
      end
      S_F_RD, S_M_H, S_P_RD: begin
        re = 1'b1;
        ra = waddr(bp32 - 32'd4);
      end
      S_S_ISS: begin
        re = 1'b1;
        ra = waddr(bp32 - 32'd4);
      end
      S_M_P: begin
        re = 1'b1;
        ra = waddr(bp32 - 32'd8);
      end
      S_M_N: begin
        re = 1'b1;
        ra = waddr(bp32 + msz_q - 32'd4);
      end
      S_G_EPI: begin
        we = 1'b1;
        wa = waddr(bp32 + tsz_q - 32'd4);
        wd = 32'd1;
      end
      S_T_H: begin
        we = 1'b1;
        wa = waddr(tbp_q - 32'd4);
        wd = tsz_q | 32'(tal_q);
      end
      S_T_F: begin
        we = 1'b1;
        wa = waddr(tbp_q + tsz_q - 32'd8);
        wd = tsz_q | 32'(tal_q);
      end
      default: ;
    endcase
  end

  assign in_i.ready         = (state_q == S_IDLE);
  assign out_o.valid        = out_vld_q;
  assign out_o.payload_addr = out_addr_q;
  assign out_o.status       = out_st_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    logic [31:0] sz, nsz, nbp, rsz;
    logic        pfree, nfree;
    if (!rst_ni) begin
      state_q   <= S_INIT;
      tret_q    <= S_IDLE;
      mret_q    <= S_IDLE;
      cnt_q     <= '0;
      brk_q     <= BW'(BRK_INIT);
      out_vld_q <= 1'b0;
    end else begin
      // S_RES reloads the output register itself
      if (out_vld_q && out_o.ready && state_q != S_RES) begin
        out_vld_q <= 1'b0;
      end
      case (state_q)
        S_INIT: begin
          cnt_q <= cnt_q + AW'(1);
          if (cnt_q == AW'(HEAP_WORDS - 1)) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_i.valid) begin
            op_q       <= in_i.opcode;
            res_addr_q <= '0;
            if (in_i.req_size <= 16'd8) begin
              asize_q <= MIN_BLOCK;
            end else begin
              asize_q <= (32'(in_i.req_size) + 32'd15) & SIZE_MASK;
            end
            if (in_i.opcode == OP_FREE) begin
              bp_q     <= {17'd0, in_i.block_addr};
              res_st_q <= ST_OK;
              state_q  <= S_F_RD;
            end else if (in_i.req_size == 16'd0) begin
              res_st_q <= ST_ZERO;
              state_q  <= S_RES;
            end else begin
              bp_q     <= 33'd8;
              res_st_q <= ST_OK;
              state_q  <= S_S_ISS;
            end
          end
        end
        S_F_RD: state_q <= S_F_W;
        S_F_W: begin
          tbp_q   <= bp32;
          tsz_q   <= rdata & SIZE_MASK;
          tal_q   <= 1'b0;
          tret_q  <= S_M_H;
          mret_q  <= S_RES;
          state_q <= S_T_H;
        end
        S_S_ISS: begin
          if (bp_q >= 33'(brk_q)) begin
            state_q <= S_GROW;
          end else begin
            state_q <= S_S_CHK;
          end
        end
        S_S_CHK: begin
          sz = rdata & SIZE_MASK;
          if (sz == 32'd0) begin
            state_q <= S_GROW;
          end else if (!rdata[0] && asize_q <= sz &&
                       ({1'b0, bp_q} + 34'(sz)) <= 34'(brk_q)) begin
            state_q <= S_P_RD;
          end else begin
            bp_q    <= bp_q + 33'(sz);
            state_q <= S_S_ISS;
          end
        end
        S_GROW: begin
          if ((33'(brk_q) + 33'(gsize)) > 33'(HEAP_BYTES)) begin
            res_st_q <= ST_OOM;
            state_q  <= S_RES;
          end else begin
            bp_q    <= 33'(brk_q);
            tbp_q   <= 32'(brk_q);
            tsz_q   <= gsize;
            tal_q   <= 1'b0;
            tret_q  <= S_G_EPI;
            state_q <= S_T_H;
          end
        end
        S_G_EPI: begin
          brk_q   <= brk_q + BW'(tsz_q);
          mret_q  <= S_P_RD;
          state_q <= S_M_H;
        end
        S_M_H: state_q <= S_M_P;
        S_M_P: begin
          msz_q   <= rdata & SIZE_MASK;
          state_q <= S_M_N;
        end
        S_M_N: begin
          pf_q    <= rdata;
          state_q <= S_M_E;
        end
        S_M_E: begin
          pfree = !pf_q[0];
          nfree = !rdata[0];
          nsz   = msz_q;
          nbp   = bp32;
          if (nfree) begin
            nsz = nsz + (rdata & SIZE_MASK);
          end
          if (pfree) begin
            nbp = nbp - (pf_q & SIZE_MASK);
            nsz = nsz + (pf_q & SIZE_MASK);
          end
          bp_q <= {1'b0, nbp};
          if (pfree || nfree) begin
            tbp_q   <= nbp;
            tsz_q   <= nsz;
            tal_q   <= 1'b0;
            tret_q  <= mret_q;
            state_q <= S_T_H;
          end else begin
            state_q <= mret_q;
          end
        end
        S_P_RD: state_q <= S_P_W;
        S_P_W: begin
          rsz   = rdata & SIZE_MASK;
          csz_q <= rsz;
          tbp_q <= bp32;
          tal_q <= 1'b1;
          if (rsz >= asize_q + MIN_BLOCK) begin
            tsz_q  <= asize_q;
            tret_q <= S_P_SPL;
          end else begin
            tsz_q  <= rsz;
            tret_q <= S_DONE;
          end
          state_q <= S_T_H;
        end
        S_P_SPL: begin
          tbp_q   <= bp32 + asize_q;
          tsz_q   <= csz_q - asize_q;
          tal_q   <= 1'b0;
          tret_q  <= S_DONE;
          state_q <= S_T_H;
        end
        S_T_H: state_q <= S_T_F;
        S_T_F: state_q <= tret_q;
        S_DONE: begin
          res_addr_q <= bp_q[15:0];
          state_q    <= S_RES;
        end
        S_RES: begin
          // output register free, or being drained this cycle
          if (!out_vld_q || out_o.ready) begin
            out_vld_q  <= 1'b1;
            out_addr_q <= (op_q == OP_FREE) ? 16'd0 : res_addr_q;
            out_st_q   <= res_st_q;
            state_q    <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule
